@@ hw/rtl/bse_pkg.sv @@
// Shared types and constants for the battery state-of-charge estimator.
// Holds the chemistry curve tables and the controller/datapath command types.
`default_nettype none
package bse_pkg;

  localparam int CURVE_POINTS = 11;
  localparam int CHEM_COUNT   = 5;
  localparam int MV_W         = 13;
  localparam int SOC_W        = 7;
  localparam int IDX_W        = $clog2(CURVE_POINTS);
  localparam int CHEM_W       = $clog2(CHEM_COUNT);
  localparam int LAST_SEG     = CURVE_POINTS - 2;

  localparam int DIV_DW = 28;
  localparam int DIV_VW = 9;

  localparam logic [15:0] EMA_ALPHA = 16'd47186;

  localparam logic [1:0] REG_DIVIDER_RATIO = 2'd0;
  localparam logic [1:0] REG_CELL_COUNT    = 2'd1;
  localparam logic [1:0] REG_CHEMISTRY     = 2'd2;

  localparam logic [MV_W-1:0] CURVE_MV [CHEM_COUNT][CURVE_POINTS] = '{
    '{13'd4180, 13'd4100, 13'd3990, 13'd3850, 13'd3770, 13'd3580,
      13'd3420, 13'd3330, 13'd3210, 13'd3000, 13'd2870},
    '{13'd4200, 13'd4120, 13'd4000, 13'd3900, 13'd3820, 13'd3730,
      13'd3630, 13'd3520, 13'd3420, 13'd3250, 13'd3100},
    '{13'd3600, 13'd3450, 13'd3380, 13'd3340, 13'd3300, 13'd3260,
      13'd3220, 13'd3180, 13'd3120, 13'd3050, 13'd2950},
    '{13'd1450, 13'd1400, 13'd1360, 13'd1330, 13'd1300, 13'd1270,
      13'd1240, 13'd1210, 13'd1180, 13'd1120, 13'd1050},
    '{13'd2150, 13'd2120, 13'd2100, 13'd2080, 13'd2050, 13'd2030,
      13'd2000, 13'd1980, 13'd1950, 13'd1900, 13'd1850}};

  localparam logic [SOC_W-1:0] CURVE_SOC [CHEM_COUNT][CURVE_POINTS] = '{
    '{7'd100, 7'd96, 7'd82, 7'd68, 7'd58, 7'd34, 7'd20, 7'd14, 7'd8,  7'd2, 7'd0},
    '{7'd100, 7'd96, 7'd84, 7'd72, 7'd62, 7'd50, 7'd34, 7'd20, 7'd10, 7'd2, 7'd0},
    '{7'd100, 7'd96, 7'd86, 7'd72, 7'd58, 7'd42, 7'd26, 7'd14, 7'd8,  7'd2, 7'd0},
    '{7'd100, 7'd96, 7'd88, 7'd78, 7'd64, 7'd50, 7'd36, 7'd22, 7'd12, 7'd4, 7'd0},
    '{7'd100, 7'd95, 7'd88, 7'd78, 7'd64, 7'd50, 7'd36, 7'd24, 7'd12, 7'd4, 7'd0}};

  typedef struct packed {
    logic load;
    logic pack;
    logic cdiv_go;
    logic cell_take;
    logic seg_inc;
    logic raw_sat;
    logic imul;
    logic idiv_go;
    logic raw_take;
    logic ema;
    logic ema_acc;
    logic out_load;
  } bse_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sat;
    logic hit;
    logic started;
  } bse_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/bse_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Used by the datapath for the cell split and the interpolation quotient.
`default_nettype none
module bse_divider #(
  parameter int DW = 28,
  parameter int VW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [VW:0]   trial;
  logic          qbit;
  logic [VW-1:0] rem_next;

  always_comb begin
    trial = {rem, quo[DW-1]};
    qbit  = (trial >= {1'b0, dsr});
    if (qbit) begin
      rem_next = VW'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule
`default_nettype wire

@@ hw/rtl/bse_datapath.sv @@
// Datapath: divider scaling, cell split, curve search, interpolation and smoothing.
// Depends on bse_pkg and bse_divider; driven by commands from bse_ctrl.
`default_nettype none
module bse_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         adc_mv,
  input  wire logic [15:0]         divider_ratio,
  input  wire logic [3:0]          cell_count,
  input  wire logic [2:0]          chemistry,
  input  wire bse_pkg::bse_cmd_t   cmd,
  output bse_pkg::bse_status_t     status,
  output logic [63:0]              result
);
  import bse_pkg::*;

  logic [15:0]         adc;
  logic [19:0]         pack;
  logic [19:0]         cell_mv;
  logic [IDX_W-1:0]    idx;
  logic signed [18:0]  iprod;
  logic [7:0]          den;
  logic [SOC_W-1:0]    base_soc;
  logic                neg;
  logic signed [16:0]  raw;
  logic signed [31:0]  smooth;
  logic                started;
  logic signed [43:0]  eprod;
  logic [63:0]         out_q;

  logic [CHEM_W-1:0]   chem;
  logic [3:0]          cells;
  logic [31:0]         pack_full;
  logic [IDX_W-1:0]    idx_lo;
  logic                div_start;
  logic [DIV_DW-1:0]   div_dividend;
  logic [DIV_VW-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_DW-1:0]   div_quo;
  logic signed [13:0]  dv;
  logic signed [5:0]   ds;
  logic [8:0]          den2;
  logic signed [28:0]  num;
  logic [28:0]         mag;
  logic [17:0]         raw_sum;
  logic signed [24:0]  target;
  logic signed [26:0]  diff;
  logic signed [17:0]  alpha_s;
  logic [31:0]         rnd;
  logic [6:0]          pct;

  always_comb begin
    chem      = (chemistry >= 3'(CHEM_COUNT)) ? '0 : CHEM_W'(chemistry);
    cells     = (cell_count == 4'd0) ? 4'd3 : cell_count;
    pack_full = adc * divider_ratio;
    idx_lo    = idx + 1'b1;
    dv        = $signed({1'b0, cell_mv[12:0]}) - $signed({1'b0, CURVE_MV[chem][idx_lo]});
    ds        = $signed({1'b0, 5'(CURVE_SOC[chem][idx] - CURVE_SOC[chem][idx_lo])});
    den2      = {den, 1'b0};
    num       = $signed({{1{iprod[18]}}, iprod, 9'd0}) + $signed({21'd0, den});
    if (num[28]) begin
      mag = 29'(-num) + {20'd0, den2} - 29'd1;
    end else begin
      mag = num;
    end
    div_start    = cmd.cdiv_go | cmd.idiv_go;
    div_dividend = cmd.idiv_go ? mag[DIV_DW-1:0] : DIV_DW'(pack);
    div_divisor  = cmd.idiv_go ? den2 : DIV_VW'(cells);
    if (neg) begin
      raw_sum = {3'd0, base_soc, 8'd0} - div_quo[17:0];
    end else begin
      raw_sum = {3'd0, base_soc, 8'd0} + div_quo[17:0];
    end
    target  = {raw, 8'd0};
    diff    = 27'(target) - smooth[26:0];
    alpha_s = $signed({2'b00, EMA_ALPHA});
    rnd     = smooth + 32'sd32768;
    if (smooth <= 0) begin
      pct = 7'd0;
    end else if (smooth >= 32'sd6553600) begin
      pct = 7'd100;
    end else begin
      pct = rnd[22:16];
    end
  end

  bse_divider #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      smooth  <= '0;
    end else begin
      if (cmd.load) begin
        adc <= adc_mv;
      end
      if (cmd.pack) begin
        pack <= pack_full[31:12];
      end
      if (cmd.cell_take) begin
        cell_mv <= div_quo[19:0];
        idx     <= '0;
      end
      if (cmd.seg_inc) begin
        idx <= idx_lo;
      end
      if (cmd.raw_sat) begin
        raw <= 17'sd25600;
      end
      if (cmd.imul) begin
        iprod    <= dv * ds;
        den      <= 8'(CURVE_MV[chem][idx] - CURVE_MV[chem][idx_lo]);
        base_soc <= CURVE_SOC[chem][idx_lo];
      end
      if (cmd.idiv_go) begin
        neg <= num[28];
      end
      if (cmd.raw_take) begin
        raw <= $signed(raw_sum[16:0]);
      end
      if (cmd.ema) begin
        if (!started) begin
          smooth  <= 32'(target);
          started <= 1'b1;
        end else begin
          eprod <= diff * alpha_s;
        end
      end
      if (cmd.ema_acc) begin
        smooth <= smooth + 32'(eprod >>> 18);
      end
      if (cmd.out_load) begin
        out_q <= {pct, raw, cell_mv, pack};
      end
    end
  end

  always_comb begin
    status.div_done = div_done;
    status.sat      = (cell_mv >= {7'd0, CURVE_MV[chem][0]});
    status.hit      = (idx == IDX_W'(LAST_SEG)) ||
                      (cell_mv > {7'd0, CURVE_MV[chem][idx_lo]});
    status.started  = started;
  end

  assign result = out_q;
endmodule
`default_nettype wire

@@ hw/rtl/bse_ctrl.sv @@
// Sequencer for the estimator: walks one request through the datapath steps.
// Depends on bse_pkg; owns the handshake flags of both stream sides.
`default_nettype none
module bse_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire bse_pkg::bse_status_t status,
  output bse_pkg::bse_cmd_t         cmd
);
  import bse_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PACK  = 4'd1;
  localparam logic [3:0] S_CDIV  = 4'd2;
  localparam logic [3:0] S_CWAIT = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_IMUL  = 4'd5;
  localparam logic [3:0] S_IDIV  = 4'd6;
  localparam logic [3:0] S_IWAIT = 4'd7;
  localparam logic [3:0] S_EMA   = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PACK;
        end
      end
      S_PACK: begin
        cmd.pack   = 1'b1;
        state_next = S_CDIV;
      end
      S_CDIV: begin
        cmd.cdiv_go = 1'b1;
        state_next  = S_CWAIT;
      end
      S_CWAIT: begin
        if (status.div_done) begin
          cmd.cell_take = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.sat) begin
          cmd.raw_sat = 1'b1;
          state_next  = S_EMA;
        end else if (status.hit) begin
          state_next = S_IMUL;
        end else begin
          cmd.seg_inc = 1'b1;
        end
      end
      S_IMUL: begin
        cmd.imul   = 1'b1;
        state_next = S_IDIV;
      end
      S_IDIV: begin
        cmd.idiv_go = 1'b1;
        state_next  = S_IWAIT;
      end
      S_IWAIT: begin
        if (status.div_done) begin
          cmd.raw_take = 1'b1;
          state_next   = S_EMA;
        end
      end
      S_EMA: begin
        cmd.ema    = 1'b1;
        state_next = status.started ? S_ACC : S_OUT;
      end
      S_ACC: begin
        cmd.ema_acc = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/battery_soc_estimator.sv @@
// Top level of the battery state-of-charge estimator: configuration registers,
// sequencer and datapath. Depends on bse_pkg, bse_ctrl and bse_datapath.
//
//   Channel   Direction  Contents
//   s_*       in         adc_mv request
//   m_*       out        pack_mv, cell_mv, raw_soc, soc_percent
//   cfg_*     in         register writes: divider_ratio, cell_count, chemistry
//
// The cell split is one pass of the shared bit-serial divider; below the top curve
// point a scan of the curve segments and a second divider pass for the interpolation
// follow. The next request can be accepted in the cycle after the result is loaded
// into the output register; while an earlier result is still stalled there, the
// sequencer waits. Reset is synchronous; it clears the smoothing state and resets
// the configuration registers to their defaults.
`default_nettype none
module battery_soc_estimator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // adc_mv[15:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // pack_mv[19:0], cell_mv[39:20], raw_soc[56:40],
                                      // soc_percent[63:57]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import bse_pkg::*;

  logic [15:0] divider_ratio;
  logic [3:0]  cell_count;
  logic [2:0]  chemistry;
  bse_cmd_t    cmd;
  bse_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ratio <= 16'd4096;
      cell_count    <= 4'd0;
      chemistry     <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIVIDER_RATIO: divider_ratio <= cfg_data;
        REG_CELL_COUNT:    cell_count    <= cfg_data[3:0];
        REG_CHEMISTRY:     chemistry     <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bse_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .adc_mv        (s_tdata),
    .divider_ratio (divider_ratio),
    .cell_count    (cell_count),
    .chemistry     (chemistry),
    .cmd           (cmd),
    .status        (status),
    .result        (m_tdata)
  );
endmodule
`default_nettype wire

@@ hw/rtl/bse_checker.sv @@
// Port-level checks for the battery state-of-charge estimator.
// Bound to battery_soc_estimator; uses only its ports.
`default_nettype none
module bse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while a request is in progress");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:57] <= 7'd100)
    else $error("soc_percent above 100");

  a_raw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[56:40]) >= -17'sd40960) &&
                 ($signed(m_tdata[56:40]) <= 17'sd25600))
    else $error("raw_soc out of range");
endmodule

bind battery_soc_estimator bse_checker u_bse_checker (.*);
`default_nettype wire
